### hdl/sfd_pkg.sv
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types and constants of the stuffed frame deframer.
// ----------------------------------------------------------------------------
package sfd_pkg;

  localparam int MAX_FRAME = 1024;
  localparam int CNT_W     = $clog2(MAX_FRAME + 1);
  localparam int IDX_W     = 10;
  localparam int FLEN_W    = 11;

  localparam logic [7:0] MARK_FE = 8'hFE;
  localparam logic [7:0] MARK_FF = 8'hFF;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_START   = 3'd1,
    EV_OK      = 3'd2,
    EV_ERROR   = 3'd3,
    EV_OVF     = 3'd4,
    EV_RESTART = 3'd5,
    EV_BADSTUF = 3'd6
  } event_t;

  // Received byte with its classification, as queued between front and back.
  typedef struct packed {
    logic [7:0] data;
    logic       is_fe;
    logic       is_ff;
    logic       is_zero;
  } tok_t;

endpackage

### hdl/sfd_if.sv
// ----------------------------------------------------------------------------
// sfd_in_if / sfd_out_if
// Valid/ready channels for received bytes and for deframer results.
// ----------------------------------------------------------------------------
interface sfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfd_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic       byte_valid;
  logic [7:0] byte_out;
  logic [9:0] byte_index;
  logic [10:0] frame_length;

  modport source (output valid, output event_res, output byte_valid, output byte_out,
                  output byte_index, output frame_length, input ready);
  modport sink   (input valid, input event_res, input byte_valid, input byte_out,
                  input byte_index, input frame_length, output ready);
endinterface

### hdl/sfd_front.sv
// ----------------------------------------------------------------------------
// sfd_front
// Accepts received bytes, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module sfd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  output logic              q_valid,
  input  logic              q_ready,
  output sfd_pkg::tok_t     q_tok
);
  import sfd_pkg::*;

  tok_t       buf_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;
  logic       push, pop;
  tok_t       tok_in;

  always_comb begin
    tok_in.data    = in_byte;
    tok_in.is_fe   = (in_byte == MARK_FE);
    tok_in.is_ff   = (in_byte == MARK_FF);
    tok_in.is_zero = (in_byte == 8'h00);
  end

  assign in_ready = (fill_r != 2'd2);
  assign q_valid  = (fill_r != 2'd0);
  assign q_tok    = buf_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= tok_in;
    end
  end

endmodule

### hdl/sfd_back.sv
// ----------------------------------------------------------------------------
// sfd_back
// Frame state tracking: stuffing removal, checksum, events and indexed writes.
// ----------------------------------------------------------------------------
module sfd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_ready,
  input  sfd_pkg::tok_t     q_tok,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_event,
  output logic              out_byte_valid,
  output logic [7:0]        out_byte,
  output logic [9:0]        out_index,
  output logic [10:0]       out_flen
);
  import sfd_pkg::*;

  logic              in_frame_r, in_frame_nxt;
  logic              prev_fe_r, prev_fe_nxt;
  logic              prev_ff_r, prev_ff_nxt;
  logic [7:0]        xor_r, xor_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  logic              oval_r;
  event_t            ev_r, ev_nxt;
  logic              bval_r, bval_nxt;
  logic [7:0]        bout_r, bout_nxt;
  logic [IDX_W-1:0]  bidx_r, bidx_nxt;
  logic [FLEN_W-1:0] flen_r, flen_nxt;

  logic              take;

  // Advance when the output register is empty or being drained.
  assign take    = q_valid && (!oval_r || out_ready);
  assign q_ready = !oval_r || out_ready;

  always_comb begin
    logic store;
    logic after_mark;
    logic clear;
    store        = 1'b0;
    after_mark   = prev_fe_r || prev_ff_r;
    clear        = 1'b0;
    in_frame_nxt = in_frame_r;
    prev_fe_nxt  = prev_fe_r;
    prev_ff_nxt  = prev_ff_r;
    xor_nxt      = xor_r;
    cnt_nxt      = cnt_r;
    ev_nxt       = EV_NONE;
    bval_nxt     = 1'b0;
    bout_nxt     = 8'h00;
    bidx_nxt     = '0;
    flen_nxt     = '0;

    if (!in_frame_r) begin
      if (prev_fe_r && q_tok.is_fe) begin
        in_frame_nxt = 1'b1;
        clear        = 1'b1;
        ev_nxt       = EV_START;
      end else begin
        prev_fe_nxt = q_tok.is_fe;
        prev_ff_nxt = q_tok.is_ff;
      end
    end else begin
      priority if (q_tok.is_fe && prev_fe_r) begin
        clear  = 1'b1;
        ev_nxt = EV_RESTART;
      end else if (q_tok.is_ff && prev_ff_r) begin
        if (cnt_r < CNT_W'(2) || (xor_r ^ MARK_FF) != 8'h00) begin
          ev_nxt = EV_ERROR;
        end else begin
          ev_nxt   = EV_OK;
          flen_nxt = FLEN_W'(cnt_r - CNT_W'(2));
        end
        in_frame_nxt = 1'b0;
        clear        = 1'b1;
      end else if (q_tok.is_fe || q_tok.is_ff) begin
        store = 1'b1;
      end else if (after_mark) begin
        // Drop stuffing zero silently, flag anything else.
        if (!q_tok.is_zero) begin
          ev_nxt = EV_BADSTUF;
        end
        prev_fe_nxt = 1'b0;
        prev_ff_nxt = 1'b0;
      end else begin
        store = 1'b1;
      end

      if (store) begin
        if (cnt_r >= CNT_W'(MAX_FRAME)) begin
          ev_nxt       = EV_OVF;
          in_frame_nxt = 1'b0;
          clear        = 1'b1;
        end else begin
          bval_nxt    = 1'b1;
          bout_nxt    = q_tok.data;
          bidx_nxt    = IDX_W'(cnt_r);
          cnt_nxt     = cnt_r + CNT_W'(1);
          xor_nxt     = xor_r ^ q_tok.data;
          prev_fe_nxt = q_tok.is_fe;
          prev_ff_nxt = q_tok.is_ff;
        end
      end
    end

    if (clear) begin
      xor_nxt     = 8'h00;
      cnt_nxt     = '0;
      prev_fe_nxt = 1'b0;
      prev_ff_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      prev_fe_r  <= 1'b0;
      prev_ff_r  <= 1'b0;
      xor_r      <= 8'h00;
      cnt_r      <= '0;
      oval_r     <= 1'b0;
    end else begin
      if (take) begin
        in_frame_r <= in_frame_nxt;
        prev_fe_r  <= prev_fe_nxt;
        prev_ff_r  <= prev_ff_nxt;
        xor_r      <= xor_nxt;
        cnt_r      <= cnt_nxt;
        oval_r     <= 1'b1;
      end else if (out_ready) begin
        oval_r     <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ev_r   <= ev_nxt;
      bval_r <= bval_nxt;
      bout_r <= bout_nxt;
      bidx_r <= bidx_nxt;
      flen_r <= flen_nxt;
    end
  end

  assign out_valid      = oval_r;
  assign out_event      = ev_r;
  assign out_byte_valid = bval_r;
  assign out_byte       = bout_r;
  assign out_index      = bidx_r;
  assign out_flen       = flen_r;

endmodule

### hdl/stuffed_frame_deframer_top.sv
// Each accepted byte is queued in sfd_front, then its result is registered in the sfd_back output register until taken.
// Throughput: one byte per cycle while out_if.ready keeps draining the output register of sfd_back.
// Stalls: the two-entry queue holds up to two bytes behind a stalled output register.
// Reset (rst_n low, synchronous) empties the queue and output and returns to hunting.
// ----------------------------------------------------------------------------
// stuffed_frame_deframer_top
// Byte-stuffed frame receiver with XOR checksum and indexed byte writes.
// ----------------------------------------------------------------------------
module stuffed_frame_deframer_top (
  input  logic       clk,
  input  logic       rst_n,
  sfd_in_if.sink     in_if,
  sfd_out_if.source  out_if
);
  import sfd_pkg::*;

  logic q_valid;
  logic q_ready;
  tok_t q_tok;

  sfd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .in_byte  (in_if.rx_byte),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_tok    (q_tok)
  );

  sfd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_ready        (q_ready),
    .q_tok          (q_tok),
    .out_valid      (out_if.valid),
    .out_ready      (out_if.ready),
    .out_event      (out_if.event_res),
    .out_byte_valid (out_if.byte_valid),
    .out_byte       (out_if.byte_out),
    .out_index      (out_if.byte_index),
    .out_flen       (out_if.frame_length)
  );

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the stuffed frame deframer. Streams of received
// bytes (framed packets with stuffing, corrupted packets, restarts, runts,
// line noise, and one oversized packet) go in through a bursty sender. A
// behavioral deframer in the bench predicts one result per accepted byte.
// Results are taken through a stalling receiver and checked field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import sfd_pkg::*;

  localparam int RANDOM_ITEMS = 1000;
  localparam int TAIL_CYCLES  = 8;
  localparam int CYCLE_LIMIT  = 400000;

  typedef enum int {
    FK_GOOD,
    FK_BADSUM,
    FK_RESTART,
    FK_BADSTUF,
    FK_NOISY,
    FK_RUNT
  } frame_kind_t;

  typedef struct packed {
    event_t              ev;
    logic                stored;
    logic [7:0]          data;
    logic [IDX_W-1:0]    idx;
    logic [FLEN_W-1:0]   flen;
  } deframe_res_t;

  logic clk;
  logic rst_n = 1'b0;

  sfd_in_if  in_ch();
  sfd_out_if out_ch();

  stuffed_frame_deframer_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  logic [7:0]   rx_stream[$];
  deframe_res_t pending_results[$];
  int           errors = 0;
  int           cycle_count = 0;
  logic         byte_taken = 1'b0;

  // Deframer state as the bench sees it
  logic [7:0]       last_byte = '0;
  logic             framing = 1'b0;
  logic [7:0]       frame_xor = '0;
  logic [CNT_W-1:0] frame_count = '0;

  function automatic void reset_frame();
    frame_xor   = '0;
    frame_count = '0;
    last_byte   = '0;
  endfunction

  task automatic predict_byte(input logic [7:0] b, output deframe_res_t r);
    logic after_mark;
    logic keep;
    begin
      r = '0;
      r.ev = EV_NONE;
      keep = 1'b0;
      after_mark = (last_byte == MARK_FE) || (last_byte == MARK_FF);
      if (!framing) begin
        if (last_byte == MARK_FE && b == MARK_FE) begin
          framing = 1'b1;
          reset_frame();
          r.ev = EV_START;
        end else begin
          last_byte = b;
        end
      end else if (b == MARK_FE && last_byte == MARK_FE) begin
        reset_frame();
        r.ev = EV_RESTART;
      end else if (b == MARK_FF && last_byte == MARK_FF) begin
        // closing FF goes into the checksum as well
        if (frame_count >= 2 && (frame_xor ^ MARK_FF) == 8'h00) begin
          r.ev = EV_OK;
          r.flen = FLEN_W'(frame_count - 2);
        end else begin
          r.ev = EV_ERROR;
        end
        framing = 1'b0;
        reset_frame();
      end else if (b == MARK_FE || b == MARK_FF || !after_mark) begin
        keep = 1'b1;
      end else begin
        // byte after a mark: zero is stuffing, anything else is flagged
        if (b != 8'h00) r.ev = EV_BADSTUF;
        last_byte = b;
      end

      if (keep) begin
        if (frame_count >= MAX_FRAME) begin
          r.ev = EV_OVF;
          framing = 1'b0;
          reset_frame();
        end else begin
          r.stored = 1'b1;
          r.data = b;
          r.idx = frame_count[IDX_W-1:0];
          frame_count = frame_count + 1'b1;
          frame_xor = frame_xor ^ b;
          last_byte = b;
        end
      end
    end
  endtask

  // ---------------- stimulus ----------------

  function automatic logic [7:0] rand_payload();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? MARK_FE : MARK_FF;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void push_stuffed(input logic [7:0] b);
    rx_stream.push_back(b);
    if (b == MARK_FE || b == MARK_FF) rx_stream.push_back(8'h00);
  endfunction

  task automatic push_frame(input frame_kind_t kind, input int len);
    logic [7:0] sum;
    logic [7:0] b;
    int         bad_at;
    begin
      sum = '0;
      bad_at = $urandom_range(0, len);
      rx_stream.push_back(MARK_FE);
      rx_stream.push_back(MARK_FE);
      if (kind == FK_RUNT) begin
        rx_stream.push_back(MARK_FF);
        rx_stream.push_back(MARK_FF);
      end else begin
        if (kind == FK_RESTART) begin
          // partial frame, then reopen
          repeat ($urandom_range(0, 6)) push_stuffed(rand_payload());
          rx_stream.push_back(MARK_FE);
          rx_stream.push_back(MARK_FE);
        end
        for (int i = 0; i < len; i++) begin
          if (kind == FK_BADSTUF && i == bad_at) begin
            rx_stream.push_back(MARK_FE);
            sum = sum ^ MARK_FE;
            rx_stream.push_back(8'($urandom_range(1, 8'hFD)));
          end
          if (kind == FK_NOISY && $urandom_range(0, 3) == 0)
            rx_stream.push_back(8'($urandom_range(0, 255)));
          b = rand_payload();
          sum = sum ^ b;
          push_stuffed(b);
        end
        if (kind == FK_BADSUM) sum = sum ^ 8'($urandom_range(1, 255));
        push_stuffed(sum);
        rx_stream.push_back(MARK_FF);
        rx_stream.push_back(MARK_FF);
      end
    end
  endtask

  task automatic push_random_chunk();
    int pick;
    int len;
    begin
      pick = $urandom_range(0, 99);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 80) : $urandom_range(0, 16);
      if (pick < 12) begin
        repeat ($urandom_range(1, 6))
          rx_stream.push_back(($urandom_range(0, 3) == 0) ? MARK_FE : 8'($urandom_range(0, 255)));
      end else if (pick < 20) begin
        push_frame(FK_RUNT, 0);
      end else if (pick < 65) begin
        push_frame(FK_GOOD, len);
      end else if (pick < 75) begin
        push_frame(FK_BADSUM, len);
      end else if (pick < 84) begin
        push_frame(FK_RESTART, len);
      end else if (pick < 93) begin
        push_frame(FK_BADSTUF, len);
      end else begin
        push_frame(FK_NOISY, len);
      end
    end
  endtask

  // ---------------- sender ----------------

  int burst_left = 4;
  int gap_left = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !byte_taken) begin
      // hold the byte until the transfer completes
    end else if (gap_left > 0) begin
      in_ch.valid <= 1'b0;
      gap_left--;
    end else if (rx_stream.size() > 0) begin
      in_ch.valid <= 1'b1;
      in_ch.rx_byte <= rx_stream.pop_front();
      if (burst_left > 1) begin
        burst_left--;
      end else if ($urandom_range(0, 3) == 0) begin
        burst_left = $urandom_range(20, 60);
        gap_left = 0;
      end else begin
        burst_left = $urandom_range(1, 12);
        gap_left = $urandom_range(1, 4);
      end
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // ---------------- receiver ----------------

  logic [7:0] stall_pattern = 8'hFF;
  int         stall_pos = 0;
  int         stall_rounds = 4;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= stall_pattern[stall_pos];
      if (stall_pos == 7) begin
        stall_pos = 0;
        stall_rounds--;
        if (stall_rounds == 0) begin
          stall_rounds = $urandom_range(2, 20);
          // keep at least one ready slot per pattern
          stall_pattern = ($urandom_range(0, 2) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
        end
      end else begin
        stall_pos++;
      end
    end
  end

  // ---------------- prediction and checking ----------------

  always @(posedge clk) begin : xfer_mon
    deframe_res_t want;
    byte_taken <= in_ch.valid && in_ch.ready;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        predict_byte(in_ch.rx_byte, want);
        pending_results.push_back(want);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result ev=%0d stored=%0b byte=%02h idx=%0d len=%0d",
                   $time, out_ch.event_res, out_ch.byte_valid, out_ch.byte_out,
                   out_ch.byte_index, out_ch.frame_length);
        end else begin
          want = pending_results.pop_front();
          if (out_ch.event_res !== want.ev || out_ch.byte_valid !== want.stored ||
              out_ch.byte_out !== want.data || out_ch.byte_index !== want.idx ||
              out_ch.frame_length !== want.flen) begin
            errors++;
            $display("%0t: mismatch expected ev=%0d stored=%0b byte=%02h idx=%0d len=%0d",
                     $time, want.ev, want.stored, want.data, want.idx, want.flen);
            $display("%0t:          actual   ev=%0d stored=%0b byte=%02h idx=%0d len=%0d",
                     $time, out_ch.event_res, out_ch.byte_valid, out_ch.byte_out,
                     out_ch.byte_index, out_ch.frame_length);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL stuffed_frame_deframer_top");
      $finish;
    end
  end

  initial begin : run
    int stop_at;
    in_ch.valid = 1'b0;
    in_ch.rx_byte = '0;
    out_ch.ready = 1'b0;

    // hunting noise, a lone FE that does not open a frame
    rx_stream.push_back(8'h00);
    rx_stream.push_back(MARK_FF);
    rx_stream.push_back(MARK_FE);
    rx_stream.push_back(8'h01);
    // frame with stuffed FF, FE followed by bad stuffing, then a good close
    rx_stream.push_back(MARK_FE);
    rx_stream.push_back(MARK_FE);
    rx_stream.push_back(MARK_FF);
    rx_stream.push_back(8'h00);
    rx_stream.push_back(MARK_FE);
    rx_stream.push_back(8'h05);
    rx_stream.push_back(8'h80);
    rx_stream.push_back(8'h81);
    rx_stream.push_back(MARK_FF);
    rx_stream.push_back(MARK_FF);
    // open, store FE, restart on FE FE, then a runt close
    rx_stream.push_back(MARK_FE);
    rx_stream.push_back(MARK_FE);
    rx_stream.push_back(MARK_FE);
    rx_stream.push_back(MARK_FE);
    rx_stream.push_back(MARK_FF);
    rx_stream.push_back(MARK_FF);
    // one-byte zero payload with zero checksum
    rx_stream.push_back(MARK_FE);
    rx_stream.push_back(MARK_FE);
    rx_stream.push_back(8'h00);
    rx_stream.push_back(8'h00);
    rx_stream.push_back(MARK_FF);
    rx_stream.push_back(MARK_FF);

    stop_at = rx_stream.size() + RANDOM_ITEMS / 2;
    while (rx_stream.size() < stop_at) push_random_chunk();

    // largest frame that still closes, then one that runs over
    push_frame(FK_GOOD, MAX_FRAME - 2);
    rx_stream.push_back(MARK_FE);
    rx_stream.push_back(MARK_FE);
    repeat (MAX_FRAME) push_stuffed(rand_payload());
    rx_stream.push_back(8'h5A);

    stop_at = rx_stream.size() + RANDOM_ITEMS / 2;
    while (rx_stream.size() < stop_at) push_random_chunk();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (rx_stream.size() != 0 || in_ch.valid || pending_results.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0 && pending_results.size() == 0) begin
      $display("PASS stuffed_frame_deframer_top");
    end else begin
      $display("FAIL stuffed_frame_deframer_top");
    end
    $finish;
  end

endmodule

### stuffed_frame_deframer_top.f
hdl/sfd_pkg.sv
hdl/sfd_if.sv
hdl/sfd_front.sv
hdl/sfd_back.sv
hdl/stuffed_frame_deframer_top.sv
bench/tb_top.sv
